// ===== design/tv_pkg.sv =====
// Shared types, constants and width helpers for the tetrahedron volume block.
// No dependencies; tv_front, tv_queue, tv_back and tetrahedron_volume import this package.
`default_nettype none

package tv_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int HEIGHT_W = 25;
    localparam int AREA_W   = 41;
    localparam int VOLUME_W = 56;

    // The volume is the scaled triple product divided by six.
    localparam logic [2:0] VOL_DIV = 3'd6;

    typedef struct packed {
        logic full;
        logic empty;
    } tv_q_status_t;

    // Width of the normal squared length N.
    function automatic int nn_width(input int c);
        return 4 * c + 4;
    endfunction

    // Width of the magnitude of the triple product d.
    function automatic int dm_width(input int c);
        return 3 * c + 3;
    endfunction

    // Width of the height dividend d^2 * 4^F.
    function automatic int x_width(input int c, input int f);
        return 2 * (3 * c + 3) + 2 * f;
    endfunction

endpackage

`default_nettype wire

// ===== design/tv_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; the dividend's top bits must stay below the divisor.
`default_nettype none

module tv_div #(
    parameter int DVD_W = 8,
    parameter int DVS_W = 4,
    parameter int Q_W   = 4
) (
    input  logic             clk,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [Q_W-1:0]   quotient
);

    logic [DVS_W-1:0] rem_reg [Q_W-1];
    logic [Q_W-1:0]   low_reg [Q_W-1];
    logic [DVS_W-1:0] dvs_reg [Q_W-1];
    logic [Q_W-1:0]   q_reg   [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [DVS_W-1:0] rem_in;
        logic [Q_W-1:0]   low_in;
        logic [Q_W-1:0]   q_in;
        logic [DVS_W-1:0] dvs_in;
        logic [DVS_W:0]   trial;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in = DVS_W'(dividend >> Q_W);
            assign low_in = dividend[Q_W-1:0];
            assign q_in   = '0;
            assign dvs_in = divisor;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
        end

        assign trial = {rem_in, low_in[Q_W-1]};
        assign ge    = trial >= {1'b0, dvs_in};

        always_ff @(posedge clk)
        begin
            q_reg[k] <= {q_in[Q_W-2:0], ge};
        end

        if (k < Q_W - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= ge ? DVS_W'(trial - {1'b0, dvs_in}) : DVS_W'(trial);
                low_reg[k] <= low_in << 1;
                dvs_reg[k] <= dvs_in;
            end
        end
    end

    assign quotient = q_reg[Q_W-1];

endmodule

`default_nettype wire

// ===== design/tv_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
// Depends on nothing.
`default_nettype none

module tv_isqrt #(
    parameter int R_W = 4
) (
    input  logic             clk,
    input  logic [2*R_W-1:0] radicand,
    output logic [R_W-1:0]   root
);

    logic [R_W:0]       rem_reg  [R_W-1];
    logic [2*R_W-1:0]   rad_reg  [R_W-1];
    logic [R_W-1:0]     root_reg [R_W];

    for (genvar k = 0; k < R_W; k++) begin : g_stage
        logic [R_W:0]     rem_in;
        logic [2*R_W-1:0] rad_in;
        logic [R_W-1:0]   root_in;
        logic [R_W+2:0]   cur;
        logic [R_W+2:0]   trial;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign rad_in  = radicand;
            assign root_in = '0;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        assign cur   = {rem_in, rad_in[2*R_W-1:2*R_W-2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = cur >= trial;

        always_ff @(posedge clk)
        begin
            root_reg[k] <= {root_in[R_W-2:0], ge};
        end

        if (k < R_W - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= ge ? (R_W+1)'(cur - trial) : (R_W+1)'(cur);
                rad_reg[k] <= rad_in << 2;
            end
        end
    end

    assign root = root_reg[R_W-1];

endmodule

`default_nettype wire

// ===== design/tv_front.sv =====
// Front end: edge vectors, base normal, its squared length, the triple product's magnitude and the height dividend.
// Depends on tv_pkg; seven register stages, one item per cycle.
`default_nettype none

module tv_front #(
    parameter int COORD_BITS = tv_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tv_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic signed [COORD_BITS-1:0] p [3],
    input  logic signed [COORD_BITS-1:0] a [3],
    input  logic signed [COORD_BITS-1:0] b [3],
    input  logic signed [COORD_BITS-1:0] c [3],
    output logic                         out_valid,
    output logic [tv_pkg::nn_width(COORD_BITS)-1:0]           nn,
    output logic [tv_pkg::dm_width(COORD_BITS)-1:0]           dmag,
    output logic [tv_pkg::x_width(COORD_BITS, FRAC_BITS)-1:0] x
);

    import tv_pkg::*;

    localparam int DFW    = COORD_BITS + 1;
    localparam int NW     = 2 * COORD_BITS + 2;
    localparam int PW     = 3 * COORD_BITS + 3;
    localparam int DSW    = 3 * COORD_BITS + 4;
    localparam int DMW    = dm_width(COORD_BITS);
    localparam int NNW    = nn_width(COORD_BITS);
    localparam int XW     = x_width(COORD_BITS, FRAC_BITS);
    localparam int LO_W   = DMW / 2;
    localparam int HI_W   = DMW - LO_W;
    localparam int STAGES = 7;

    logic [STAGES-1:0] vld_reg;

    logic signed [DFW-1:0]   u_reg [3];
    logic signed [DFW-1:0]   w_reg [3];
    logic signed [DFW-1:0]   v1_reg [3];
    logic signed [2*DFW-1:0] m_reg [6];
    logic signed [DFW-1:0]   v2_reg [3];
    logic signed [NW-1:0]    n_reg [3];
    logic signed [DFW-1:0]   v3_reg [3];
    logic signed [NNW-1:0]   sq_reg [3];
    logic signed [PW-1:0]    nv_reg [3];
    logic [NNW-1:0]          nn5_reg;
    logic [DMW-1:0]          dm5_reg;
    logic [NNW-1:0]          nn6_reg;
    logic [DMW-1:0]          dm6_reg;
    logic [2*HI_W-1:0]       hh_reg;
    logic [HI_W+LO_W-1:0]    hl_reg;
    logic [2*LO_W-1:0]       ll_reg;
    logic [NNW-1:0]          nn7_reg;
    logic [DMW-1:0]          dm7_reg;
    logic [XW-1:0]           x_reg;

    logic signed [DSW-1:0]   dsum_next;
    logic [DMW-1:0]          dm_next;
    logic [HI_W-1:0]         dm_hi;
    logic [LO_W-1:0]         dm_lo;
    logic [XW-1:0]           x_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_comb
    begin
        dsum_next = DSW'(nv_reg[0]) + DSW'(nv_reg[1]) + DSW'(nv_reg[2]);
        dm_next   = dsum_next < 0 ? DMW'(-dsum_next) : DMW'(dsum_next);
        dm_hi     = dm5_reg[DMW-1:LO_W];
        dm_lo     = dm5_reg[LO_W-1:0];
        x_next    = ((XW'(hh_reg) << (2 * LO_W)) + (XW'(hl_reg) << (LO_W + 1))
                     + XW'(ll_reg)) << (2 * FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_reg[i]  <= DFW'(b[i]) - DFW'(a[i]);
            w_reg[i]  <= DFW'(c[i]) - DFW'(a[i]);
            v1_reg[i] <= DFW'(p[i]) - DFW'(a[i]);
            v2_reg[i] <= v1_reg[i];
            v3_reg[i] <= v2_reg[i];
            sq_reg[i] <= n_reg[i] * n_reg[i];
            nv_reg[i] <= n_reg[i] * v3_reg[i];
        end
        m_reg[0] <= u_reg[1] * w_reg[2];
        m_reg[1] <= u_reg[2] * w_reg[1];
        m_reg[2] <= u_reg[2] * w_reg[0];
        m_reg[3] <= u_reg[0] * w_reg[2];
        m_reg[4] <= u_reg[0] * w_reg[1];
        m_reg[5] <= u_reg[1] * w_reg[0];
        n_reg[0] <= NW'(m_reg[0] - m_reg[1]);
        n_reg[1] <= NW'(m_reg[2] - m_reg[3]);
        n_reg[2] <= NW'(m_reg[4] - m_reg[5]);
        nn5_reg  <= $unsigned(sq_reg[0]) + $unsigned(sq_reg[1]) + $unsigned(sq_reg[2]);
        dm5_reg  <= dm_next;
        hh_reg   <= dm_hi * dm_hi;
        hl_reg   <= dm_hi * dm_lo;
        ll_reg   <= dm_lo * dm_lo;
        nn6_reg  <= nn5_reg;
        dm6_reg  <= dm5_reg;
        nn7_reg  <= nn6_reg;
        dm7_reg  <= dm6_reg;
        x_reg    <= x_next;
    end

    assign out_valid = vld_reg[STAGES-1];
    assign nn        = nn7_reg;
    assign dmag      = dm7_reg;
    assign x         = x_reg;

endmodule

`default_nettype wire

// ===== design/tv_queue.sv =====
// Two-entry item queue between the front end and the back end.
// Depends on tv_pkg for the status struct; the back end drains it every cycle.
`default_nettype none

module tv_queue #(
    parameter int W = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [W-1:0]         din,
    output logic                 out_valid,
    output logic [W-1:0]         dout,
    output tv_pkg::tv_q_status_t status
);

    import tv_pkg::*;

    logic [W-1:0] mem [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         pop;

    assign pop          = count_reg != 2'd0;
    assign status.empty = count_reg == 2'd0;
    assign status.full  = count_reg == 2'd2;
    assign out_valid    = pop;
    assign dout         = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

// ===== design/tv_back.sv =====
// Back end: divider, root and reciprocal pipelines for height, area and volume, aligned to one output.
// Depends on tv_pkg, tv_div and tv_isqrt.
`default_nettype none

module tv_back #(
    parameter int COORD_BITS = tv_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tv_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic [tv_pkg::nn_width(COORD_BITS)-1:0]           nn,
    input  logic [tv_pkg::dm_width(COORD_BITS)-1:0]           dmag,
    input  logic [tv_pkg::x_width(COORD_BITS, FRAC_BITS)-1:0] x,
    output logic                          done,
    output logic [tv_pkg::HEIGHT_W-1:0]   height,
    output logic [tv_pkg::AREA_W-1:0]     base_area,
    output logic [tv_pkg::VOLUME_W-1:0]   volume,
    output logic                          degenerate
);

    import tv_pkg::*;

    localparam int NNW   = nn_width(COORD_BITS);
    localparam int DMW   = dm_width(COORD_BITS);
    localparam int XW    = x_width(COORD_BITS, FRAC_BITS);
    localparam int QH    = 2 * (COORD_BITS + 1 + FRAC_BITS);
    localparam int RH    = QH / 2;
    localparam int HL    = QH + RH;
    localparam int RA    = NNW / 2 + FRAC_BITS;
    localparam int VW    = DMW + FRAC_BITS;
    localparam int QV    = 3 * COORD_BITS + FRAC_BITS;
    localparam int DIG   = 16;
    localparam int ND    = (VW + DIG - 1) / DIG;
    localparam int YW    = ND * DIG;
    localparam int VR_W  = DIG + 3;
    localparam int RCP_S = VR_W + 3;
    localparam int PAD_A = HL - RA;
    localparam int PAD_V = HL - ND;

    // Reciprocal of the volume divisor, exact for every partial dividend below 2^VR_W.
    localparam logic [VR_W:0] RCP =
        (VR_W+1)'((2 ** RCP_S + int'(VOL_DIV) - 1) / int'(VOL_DIV));

    logic [QH-1:0]   qh;
    logic [RH-1:0]   hroot;
    logic [RA-1:0]   aroot;
    logic [QV-1:0]   qv;
    logic [2*RA-1:0] area_rad;
    logic [YW-1:0]   vol_y;

    logic [2:0]      vrem_reg [ND-1];
    logic [YW-1:0]   vy_reg   [ND-1];
    logic [YW-1:0]   vq_reg   [ND];

    logic [HL-1:0]   vld_reg;
    logic [HL-1:0]   dgn_reg;
    logic [RA-1:0]   area_dly_reg [PAD_A];
    logic [QV-1:0]   vol_dly_reg  [PAD_V];

    logic                done_reg;
    logic                dgn_out_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [AREA_W-1:0]   area_reg;
    logic [VOLUME_W-1:0] volume_reg;

    assign area_rad = (2 * RA)'(nn) << (2 * FRAC_BITS);
    assign vol_y    = YW'(dmag) << FRAC_BITS;

    tv_div #(.DVD_W(XW), .DVS_W(NNW), .Q_W(QH)) u_hdiv (
        .clk      (clk),
        .dividend (x),
        .divisor  (nn),
        .quotient (qh)
    );

    tv_isqrt #(.R_W(RH)) u_hroot (
        .clk      (clk),
        .radicand (qh),
        .root     (hroot)
    );

    tv_isqrt #(.R_W(RA)) u_aroot (
        .clk      (clk),
        .radicand (area_rad),
        .root     (aroot)
    );

    // The volume quotient is formed one 16-bit digit per stage by reciprocal multiplication.
    for (genvar k = 0; k < ND; k++) begin : g_vstage
        logic [2:0]      rem_in;
        logic [YW-1:0]   y_in;
        logic [YW-1:0]   q_in;
        logic [VR_W-1:0] part;
        logic [2*VR_W:0] prod;
        logic [DIG-1:0]  qd;
        logic [VR_W-1:0] rest;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign y_in   = vol_y;
            assign q_in   = '0;
        end else begin : g_rest
            assign rem_in = vrem_reg[k-1];
            assign y_in   = vy_reg[k-1];
            assign q_in   = vq_reg[k-1];
        end

        assign part = {rem_in, y_in[YW-1 -: DIG]};
        assign prod = (2*VR_W+1)'(part) * (2*VR_W+1)'(RCP);
        assign qd   = prod[RCP_S +: DIG];
        assign rest = part - VR_W'(qd) * VR_W'(VOL_DIV);

        always_ff @(posedge clk)
        begin
            vq_reg[k] <= {q_in[YW-DIG-1:0], qd};
        end

        if (k < ND - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                vrem_reg[k] <= rest[2:0];
                vy_reg[k]   <= y_in << DIG;
            end
        end
    end

    assign qv = QV'(vq_reg[ND-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[HL-2:0], in_valid};
            done_reg <= vld_reg[HL-1];
        end
    end

    always_ff @(posedge clk)
    begin
        dgn_reg         <= {dgn_reg[HL-2:0], nn == '0};
        area_dly_reg[0] <= aroot;
        for (int i = 1; i < PAD_A; i++)
        begin
            area_dly_reg[i] <= area_dly_reg[i-1];
        end
        vol_dly_reg[0] <= qv;
        for (int i = 1; i < PAD_V; i++)
        begin
            vol_dly_reg[i] <= vol_dly_reg[i-1];
        end
        dgn_out_reg <= dgn_reg[HL-1];
        if (dgn_reg[HL-1])
        begin
            height_reg <= '0;
            area_reg   <= '0;
            volume_reg <= '0;
        end
        else
        begin
            height_reg <= HEIGHT_W'(hroot);
            area_reg   <= AREA_W'(area_dly_reg[PAD_A-1] >> 1);
            volume_reg <= VOLUME_W'(vol_dly_reg[PAD_V-1]);
        end
    end

    assign done       = done_reg;
    assign degenerate = dgn_out_reg;
    assign height     = height_reg;
    assign base_area  = area_reg;
    assign volume     = volume_reg;

endmodule

`default_nettype wire

// ===== design/tetrahedron_volume.sv =====
// Throughput: one item per cycle; busy stays low since the back end drains the queue each cycle.
// The height path (long divider followed by the root pipeline) sets the latency.
// Reset (rst_n, asynchronous, active low) clears the valid pipelines and the queue only.
// Results cannot be held off by the receiver; each shows for one cycle with done.
`default_nettype none

module tetrahedron_volume #(
    parameter int COORD_BITS = tv_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tv_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] apex_x,
    input  logic signed [COORD_BITS-1:0] apex_y,
    input  logic signed [COORD_BITS-1:0] apex_z,
    input  logic signed [COORD_BITS-1:0] base_a_x,
    input  logic signed [COORD_BITS-1:0] base_a_y,
    input  logic signed [COORD_BITS-1:0] base_a_z,
    input  logic signed [COORD_BITS-1:0] base_b_x,
    input  logic signed [COORD_BITS-1:0] base_b_y,
    input  logic signed [COORD_BITS-1:0] base_b_z,
    input  logic signed [COORD_BITS-1:0] base_c_x,
    input  logic signed [COORD_BITS-1:0] base_c_y,
    input  logic signed [COORD_BITS-1:0] base_c_z,
    output logic                         done,
    output logic [tv_pkg::HEIGHT_W-1:0]  height,
    output logic [tv_pkg::AREA_W-1:0]    base_area,
    output logic [tv_pkg::VOLUME_W-1:0]  volume,
    output logic                         degenerate
);

    import tv_pkg::*;

    localparam int NNW = nn_width(COORD_BITS);
    localparam int DMW = dm_width(COORD_BITS);
    localparam int XW  = x_width(COORD_BITS, FRAC_BITS);
    localparam int QW  = NNW + DMW + XW;
    localparam int LAT = 9 + 3 * (COORD_BITS + 1 + FRAC_BITS);

    logic signed [COORD_BITS-1:0] p [3];
    logic signed [COORD_BITS-1:0] a [3];
    logic signed [COORD_BITS-1:0] b [3];
    logic signed [COORD_BITS-1:0] c [3];

    logic           accept;
    logic           f_valid;
    logic [NNW-1:0] f_nn;
    logic [DMW-1:0] f_dmag;
    logic [XW-1:0]  f_x;
    logic           q_valid;
    logic [QW-1:0]  q_data;
    tv_q_status_t   q_status;

    assign p[0] = apex_x;
    assign p[1] = apex_y;
    assign p[2] = apex_z;
    assign a[0] = base_a_x;
    assign a[1] = base_a_y;
    assign a[2] = base_a_z;
    assign b[0] = base_b_x;
    assign b[1] = base_b_y;
    assign b[2] = base_b_z;
    assign c[0] = base_c_x;
    assign c[1] = base_c_y;
    assign c[2] = base_c_z;

    assign busy   = q_status.full;
    assign accept = start && !busy;

    tv_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .p         (p),
        .a         (a),
        .b         (b),
        .c         (c),
        .out_valid (f_valid),
        .nn        (f_nn),
        .dmag      (f_dmag),
        .x         (f_x)
    );

    tv_queue #(.W(QW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid),
        .din       ({f_nn, f_dmag, f_x}),
        .out_valid (q_valid),
        .dout      (q_data),
        .status    (q_status)
    );

    tv_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .nn         (q_data[QW-1:DMW+XW]),
        .dmag       (q_data[DMW+XW-1:XW]),
        .x          (q_data[XW-1:0]),
        .done       (done),
        .height     (height),
        .base_area  (base_area),
        .volume     (volume),
        .degenerate (degenerate)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(f_valid && q_status.full))
        else $error("item pushed into a full queue");

    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (height == '0 && base_area == '0 && volume == '0))
        else $error("degenerate item with nonzero result");

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result without an item accepted at the expected time");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tv_checker.sv =====
// Result checker for the tetrahedron volume block: it predicts each item and compares results.
// Depends on tv_pkg for the result widths.
`default_nettype none

module tv_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic signed [15:0]           apex_x,
    input  logic signed [15:0]           apex_y,
    input  logic signed [15:0]           apex_z,
    input  logic signed [15:0]           base_a_x,
    input  logic signed [15:0]           base_a_y,
    input  logic signed [15:0]           base_a_z,
    input  logic signed [15:0]           base_b_x,
    input  logic signed [15:0]           base_b_y,
    input  logic signed [15:0]           base_b_z,
    input  logic signed [15:0]           base_c_x,
    input  logic signed [15:0]           base_c_y,
    input  logic signed [15:0]           base_c_z,
    input  logic                         done,
    input  logic [tv_pkg::HEIGHT_W-1:0]  height,
    input  logic [tv_pkg::AREA_W-1:0]    base_area,
    input  logic [tv_pkg::VOLUME_W-1:0]  volume,
    input  logic                         degenerate,
    output int                           errors,
    output int                           pending
);

    localparam int WIDE = 160;

    typedef struct {
        logic [tv_pkg::HEIGHT_W-1:0] height;
        logic [tv_pkg::AREA_W-1:0]   area;
        logic [tv_pkg::VOLUME_W-1:0] volume;
        logic                        degenerate;
    } solid_t;

    solid_t expected_solids[$];

    function automatic logic [WIDE-1:0] int_sqrt(input logic [WIDE-1:0] x);
        logic [WIDE-1:0] root;
        logic [WIDE-1:0] trial;
        root = '0;
        for (int i = WIDE / 2 - 1; i >= 0; i--) begin
            trial = root | (WIDE'(1) << i);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    function automatic solid_t measure_solid(
        input logic signed [15:0] p0, p1, p2, a0, a1, a2,
        input logic signed [15:0] b0, b1, b2, c0, c1, c2
    );
        logic signed [63:0] u0, u1, u2, w0, w1, w2, v0, v1, v2, n0, n1, n2;
        logic signed [WIDE-1:0] nw0, nw1, nw2, vw0, vw1, vw2;
        logic signed [WIDE-1:0] triple;
        logic [WIDE-1:0] norm_sq;
        logic [WIDE-1:0] dmag;
        solid_t s;
        u0 = 64'(b0) - 64'(a0); u1 = 64'(b1) - 64'(a1); u2 = 64'(b2) - 64'(a2);
        w0 = 64'(c0) - 64'(a0); w1 = 64'(c1) - 64'(a1); w2 = 64'(c2) - 64'(a2);
        v0 = 64'(p0) - 64'(a0); v1 = 64'(p1) - 64'(a1); v2 = 64'(p2) - 64'(a2);
        n0 = u1 * w2 - u2 * w1;
        n1 = u2 * w0 - u0 * w2;
        n2 = u0 * w1 - u1 * w0;
        nw0 = WIDE'(n0); nw1 = WIDE'(n1); nw2 = WIDE'(n2);
        vw0 = WIDE'(v0); vw1 = WIDE'(v1); vw2 = WIDE'(v2);
        norm_sq = $unsigned(nw0 * nw0 + nw1 * nw1 + nw2 * nw2);
        triple = nw0 * vw0 + nw1 * vw1 + nw2 * vw2;
        dmag = $unsigned(triple < 0 ? -triple : triple);
        if (norm_sq == 0) begin
            s.height = '0;
            s.area = '0;
            s.volume = '0;
            s.degenerate = 1'b1;
        end else begin
            s.height = tv_pkg::HEIGHT_W'(int_sqrt(((dmag * dmag) << 16) / norm_sq));
            s.area = tv_pkg::AREA_W'(int_sqrt(norm_sq << 16) >> 1);
            s.volume = tv_pkg::VOLUME_W'((dmag << 8) / 6);
            s.degenerate = 1'b0;
        end
        return s;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk) begin
        solid_t s;
        if (rst_n && start && !busy)
            expected_solids.push_back(measure_solid(apex_x, apex_y, apex_z,
                base_a_x, base_a_y, base_a_z, base_b_x, base_b_y, base_b_z,
                base_c_x, base_c_y, base_c_z));
        if (rst_n && done) begin
            if (expected_solids.size() == 0) begin
                report("unexpected item", 64'(0), 64'(0));
            end else begin
                s = expected_solids.pop_front();
                if (height !== s.height) report("height", 64'(height), 64'(s.height));
                if (base_area !== s.area) report("base_area", 64'(base_area), 64'(s.area));
                if (volume !== s.volume) report("volume", 64'(volume), 64'(s.volume));
                if (degenerate !== s.degenerate)
                    report("degenerate", 64'(degenerate), 64'(s.degenerate));
            end
        end
        pending = expected_solids.size();
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench top for the tetrahedron volume block: clock, reset, stimulus and verdict.
// Depends on tv_pkg, tetrahedron_volume and tv_checker.
`default_nettype none

module tb;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [15:0] apex_x = '0, apex_y = '0, apex_z = '0;
    logic signed [15:0] base_a_x = '0, base_a_y = '0, base_a_z = '0;
    logic signed [15:0] base_b_x = '0, base_b_y = '0, base_b_z = '0;
    logic signed [15:0] base_c_x = '0, base_c_y = '0, base_c_z = '0;
    logic done;
    logic [tv_pkg::HEIGHT_W-1:0] height;
    logic [tv_pkg::AREA_W-1:0] base_area;
    logic [tv_pkg::VOLUME_W-1:0] volume;
    logic degenerate;
    int errors;
    int pending;
    int idle_pct;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    tetrahedron_volume dut (.*);
    tv_checker checker_i (.*);

    task automatic send(input int px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        apex_x <= 16'(px); apex_y <= 16'(py); apex_z <= 16'(pz);
        base_a_x <= 16'(ax); base_a_y <= 16'(ay); base_a_z <= 16'(az);
        base_b_x <= 16'(bx); base_b_y <= 16'(by); base_b_z <= 16'(bz);
        base_c_x <= 16'(cx); base_c_y <= 16'(cy); base_c_z <= 16'(cz);
        do @(posedge clk); while (busy);
    endtask

    function automatic int rnd(input int span);
        return $signed($urandom_range(2 * span)) - span;
    endfunction

    task automatic send_random();
        int ax, ay, az, dx, dy, dz, k, m, mode;
        mode = $urandom_range(9);
        ax = rnd(20000); ay = rnd(20000); az = rnd(20000);
        if (mode < 4) begin
            send($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else if (mode < 6) begin
            send(ax + rnd(50), ay + rnd(50), az + rnd(50), ax, ay, az,
                 ax + rnd(50), ay + rnd(50), az + rnd(50),
                 ax + rnd(50), ay + rnd(50), az + rnd(50));
        end else if (mode < 8) begin
            dx = rnd(100); dy = rnd(100); dz = rnd(100);
            k = rnd(100); m = rnd(100);
            send(rnd(32767), rnd(32767), rnd(32767), ax, ay, az,
                 ax + k * dx, ay + k * dy, az + k * dz, ax + m * dx, ay + m * dy, az + m * dz);
        end else begin
            dx = rnd(5000); dy = rnd(5000); k = rnd(3); m = rnd(3);
            send(ax + k * dx, ay + m * dy, az, ax, ay, az,
                 ax + dx, ay, az, ax, ay + dy, az);
        end
    endtask

    initial
    begin
        #(20 * 400000);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        idle_pct = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send(1, 1, 1, 0, 0, 0, 1, 0, 0, 0, 1, 0);
        send(-32768, -32768, 32767, -32768, -32768, -32768,
             32767, -32768, -32768, -32768, 32767, -32768);
        send(32767, 32767, -32768, 32767, 32767, 32767,
             -32768, 32767, 32767, 32767, -32768, 32767);
        send(32767, -32768, 32767, -32768, 32767, -32768,
             32767, 32767, -32768, -32768, -32768, 32767);
        send(-32768, 32767, -32768, 32767, -32768, 32767,
             -32768, -32768, 32767, 32767, 32767, -32768);
        send(5, 5, 0, 0, 0, 0, 10, 0, 0, 0, 10, 0);
        send(7, 8, 9, 1, 1, 1, 2, 2, 2, 3, 3, 3);
        send(7, 8, 9, 4, 4, 4, 4, 4, 4, 4, 4, 4);
        send(100, -3, 77, 1, 2, 3, 1, 2, 3, 9, 9, 9);
        send(-1, -1, -1, 0, 0, 0, -1, 0, 0, 0, -1, 0);
        send(32767, 32767, 32767, -32768, -32768, -32768,
             -32768, -32768, -32768, 32767, 32767, 32767);
        send(3, 3, 3, 0, 0, 0, 2, 0, 0, 0, 2, 0);
        start <= 1'b0;
        wait (pending == 0);
        @(posedge clk);
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1) ? 56 : (phase == 3) ? 24 : 0;
            repeat (435) send_random();
            start <= 1'b0;
            wait (pending == 0);
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
